// ===== rtl/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg: shared types and constants for the adaptive sine saturation drive
// Fixed-point constants, serial unit sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package asd_pkg;

  // sample format, signed Q4.(SampleBits-4)
  localparam int SampleBits = 24;
  localparam int SampleFrac = SampleBits - 4;
  localparam int AngFrac    = 28;
  localparam int SinFrac    = 22;
  localparam int AngShift   = AngFrac - SampleFrac;
  localparam int SinShift   = AngFrac - SinFrac;
  localparam int OutShift   = AngFrac + SinFrac - SampleFrac;

  // angle word, Q28 signed, holds +-8 plus one turn
  localparam int XW = 34;

  localparam longint KTwoPiL  = 64'sd1686629711;
  localparam longint KPiL     = 64'sd843314869;
  localparam longint KInvL    = 64'sd42722829;
  localparam longint KDenL    = 64'sd13246752883;
  // smallest angle whose truncated quotient reaches one turn
  localparam longint WrapThrL = ((64'sd1 <<< 56) + KInvL - 64'sd1) / KInvL;

  localparam logic signed [XW-1:0] KTwoPi  = XW'(KTwoPiL);
  localparam logic signed [XW-1:0] KPi     = XW'(KPiL);
  localparam logic signed [XW-1:0] WrapThr = XW'(WrapThrL);

  // serial multiplier operand width and divider sizes
  localparam int MW   = 32;
  localparam int MCW  = $clog2(MW);
  localparam int QW   = 24;
  localparam int QCW  = $clog2(QW);
  localparam int RW   = 36;
  localparam int DW   = 38;
  localparam logic signed [DW-1:0] KDen = DW'(KDenL);

  localparam int KnobBits   = 16;
  localparam int CfgIdxBits = 2;
  localparam int InteBits   = 17;
  localparam logic [InteBits-1:0] InteOne = InteBits'(65536);
  localparam int BlendBits  = 23;
  localparam logic [BlendBits-1:0] BlendOne = BlendBits'(1 << SinFrac);

  typedef enum logic [CfgIdxBits-1:0] {
    REG_DRIVE_KNOB    = 2'd0,
    REG_EFFECT_ENABLE = 2'd1,
    REG_SPARE2        = 2'd2,
    REG_SPARE3        = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_FOLD,
    ST_HALF,
    ST_MSTART,
    ST_PROD,
    ST_QUOT,
    ST_BLEND,
    ST_MIX,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic mul_start;
    logic div_start;
  } seq_ctl_t;

endpackage

// ===== rtl/asd_mul.sv =====
// ----------------------------------------------------------------------------
// asd_mul: bit-serial unsigned multiplier
// One multiplier bit per cycle, shift-add into a right-shifting accumulator.
// ----------------------------------------------------------------------------
module asd_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [asd_pkg::MW-1:0]         a_i,
  input  logic [asd_pkg::MW-1:0]         b_i,
  output logic                           done_o,
  output logic [2*asd_pkg::MW-1:0]       prod_o
);

  logic                          busy_q, done_q;
  logic [asd_pkg::MCW-1:0]       cnt_q;
  logic [asd_pkg::MW-1:0]        a_q, b_q;
  logic [2*asd_pkg::MW-1:0]      acc_q;
  logic [asd_pkg::MW:0]          sum;

  assign sum = {1'b0, acc_q[2*asd_pkg::MW-1:asd_pkg::MW]}
             + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= asd_pkg::MCW'(asd_pkg::MW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      // add on the low multiplier bit, then shift one place right
      acc_q <= {sum, acc_q[asd_pkg::MW-1:1]};
      b_q   <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/asd_div.sv =====
// ----------------------------------------------------------------------------
// asd_div: bit-serial restoring divider
// One quotient bit per cycle; the partial remainder starts below the divisor.
// ----------------------------------------------------------------------------
module asd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [asd_pkg::RW-1:0]     rem_i,
  input  logic [asd_pkg::RW-1:0]     den_i,
  output logic                       done_o,
  output logic [asd_pkg::QW-1:0]     quot_o
);

  logic                      busy_q, done_q;
  logic [asd_pkg::QCW-1:0]   cnt_q;
  logic [asd_pkg::RW-1:0]    rem_q, den_q;
  logic [asd_pkg::QW-1:0]    quot_q;
  logic [asd_pkg::RW:0]      shl, diff;
  logic                      fits;

  assign shl  = {rem_q, 1'b0};
  assign diff = shl - {1'b0, den_q};
  assign fits = shl >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= asd_pkg::QCW'(asd_pkg::QW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[asd_pkg::RW-1:0] : shl[asd_pkg::RW-1:0];
      quot_q <= {quot_q[asd_pkg::QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/adaptive_sine_saturation_drive.sv =====
// ----------------------------------------------------------------------------
// adaptive_sine_saturation_drive: Bhaskara sine waveshaper with adaptive blend
// Each sample passes range reduction, the serial multiplier, the serial
// divider, blend and mixing, using the two bit-serial units in turn; a new
// beat is taken only once the sequencer is idle again, also while a result
// still waits in the output register. Reset clears both channel histories,
// the configuration registers, the sequencer state and the output valid flag.
// ----------------------------------------------------------------------------
module adaptive_sine_saturation_drive (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [23:0] sample
  input  logic [1:0]  s_axis_tuser_i,   // [0] channel, [1] clear_history
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [23:0] out_sample
);

  localparam int SB = asd_pkg::SampleBits;
  localparam int XW = asd_pkg::XW;
  localparam int MW = asd_pkg::MW;
  localparam int QW = asd_pkg::QW;
  localparam int RW = asd_pkg::RW;
  localparam int DW = asd_pkg::DW;
  localparam int BB = asd_pkg::BlendBits;
  localparam int PW = 2 * SB;
  localparam int AW = PW + asd_pkg::AngShift + 2;

  asd_pkg::seq_state_e state_q, state_d;
  asd_pkg::seq_ctl_t   ctl;

  // configuration
  logic [asd_pkg::KnobBits-1:0] knob_q;
  logic                         en_q;

  // per-sample registers
  logic signed [SB-1:0] dry_q;
  logic                 ch_q;
  logic signed [XW-1:0] x_q;
  logic                 neg_half_q;
  logic                 xp_neg_q;
  logic signed [SB-1:0] sat_q;
  logic [BB-1:0]        blend_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [SB-1:0] prev_q [2];

  logic                 out_valid_q;
  logic [SB-1:0]        out_data_q;

  logic                 in_beat, out_free;

  // serial unit ports
  logic                  mul_done, div_done;
  logic [2*MW-1:0]       mul_prod;
  logic [QW-1:0]         quot;
  logic signed [XW-1:0]  pmx, pmx_mag;
  logic [XW-1:0]         xp_mag;
  logic signed [DW-1:0]  xp_s, den_full;
  logic [RW-1:0]         den_pos, rem_init;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == asd_pkg::ST_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asd_pkg::ST_IDLE:   if (in_beat) state_d = asd_pkg::ST_WRAP;
      asd_pkg::ST_WRAP:   state_d = asd_pkg::ST_FOLD;
      asd_pkg::ST_FOLD:   state_d = asd_pkg::ST_HALF;
      asd_pkg::ST_HALF:   state_d = asd_pkg::ST_MSTART;
      asd_pkg::ST_MSTART: state_d = asd_pkg::ST_PROD;
      asd_pkg::ST_PROD:   if (mul_done) state_d = asd_pkg::ST_QUOT;
      asd_pkg::ST_QUOT:   if (div_done) state_d = asd_pkg::ST_BLEND;
      asd_pkg::ST_BLEND:  state_d = asd_pkg::ST_MIX;
      asd_pkg::ST_MIX:    state_d = asd_pkg::ST_EMIT;
      asd_pkg::ST_EMIT:   if (out_free) state_d = asd_pkg::ST_IDLE;
      default:            state_d = asd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.mul_start = (state_q == asd_pkg::ST_MSTART);
    ctl.div_start = (state_q == asd_pkg::ST_PROD) && mul_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // configuration registers; spare indexes drop the write
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knob_q <= '0;
      en_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (asd_pkg::cfg_reg_e'(cfg_index_i))
        asd_pkg::REG_DRIVE_KNOB:    knob_q <= cfg_data_i;
        asd_pkg::REG_EFFECT_ENABLE: en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // range reduction: one turn off by the truncated quotient, wrap negatives
  // up, fold the upper half-turn down and remember to negate
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      asd_pkg::ST_IDLE: begin
        if (in_beat) begin
          dry_q <= $signed(s_axis_tdata_i);
          ch_q  <= s_axis_tuser_i[0];
          x_q   <= $signed({{(XW-SB){s_axis_tdata_i[SB-1]}}, s_axis_tdata_i})
                   <<< asd_pkg::AngShift;
        end
      end
      asd_pkg::ST_WRAP: begin
        if (x_q >= asd_pkg::WrapThr)       x_q <= x_q - asd_pkg::KTwoPi;
        else if (x_q <= -asd_pkg::WrapThr) x_q <= x_q + asd_pkg::KTwoPi;
      end
      asd_pkg::ST_FOLD: begin
        if (x_q < 0) x_q <= x_q + asd_pkg::KTwoPi;
      end
      asd_pkg::ST_HALF: begin
        neg_half_q <= x_q > asd_pkg::KPi;
        if (x_q > asd_pkg::KPi) x_q <= x_q - asd_pkg::KPi;
      end
      asd_pkg::ST_MSTART: begin
        xp_neg_q <= pmx < 0;
      end
      default: ;
    endcase
  end

  // x*(pi-x) in sign-magnitude; x is never negative after the fold
  assign pmx     = asd_pkg::KPi - x_q;
  assign pmx_mag = (pmx < 0) ? -pmx : pmx;

  asd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.mul_start),
    .a_i     (x_q[MW-1:0]),
    .b_i     (pmx_mag[MW-1:0]),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // truncate the Q56 product toward zero, then build 49.348 - 4*xp
  assign xp_mag   = mul_prod[XW+asd_pkg::AngFrac-1:asd_pkg::AngFrac];
  assign xp_s     = xp_neg_q ? -$signed({{(DW-XW){1'b0}}, xp_mag})
                             :  $signed({{(DW-XW){1'b0}}, xp_mag});
  assign den_full = asd_pkg::KDen - (xp_s <<< 2);
  assign den_pos  = (den_full <= 0) ? RW'(1) : den_full[RW-1:0];
  // numerator 16*xp*2^22: the top part enters as the starting remainder
  assign rem_init = {xp_mag[RW-3:0], 2'b00};

  asd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .rem_i   (rem_init),
    .den_i   (den_pos),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // --------------------------------------------------------------------------
  // blend and cross-fade
  // --------------------------------------------------------------------------
  logic [asd_pkg::InteBits+2:0] knob8;
  logic [asd_pkg::InteBits-1:0] inte;
  logic signed [SB:0]           hsum;
  logic [SB:0]                  hmag;
  logic [SB+asd_pkg::InteBits:0] bprod;
  logic [SB:0]                  braw;
  logic [BB:0]                  wgt;
  logic signed [AW-1:0]         acc;
  logic signed [AW-asd_pkg::OutShift-1:0] res;
  logic signed [SB-1:0]         res_sat;

  assign knob8 = {1'b0, knob_q, 3'b000};
  assign inte  = !en_q ? '0
               : (knob8 > (asd_pkg::InteBits+3)'(asd_pkg::InteOne)) ? asd_pkg::InteOne
               : knob8[asd_pkg::InteBits-1:0];
  assign hsum  = $signed({prev_q[ch_q][SB-1], prev_q[ch_q]})
               + $signed({sat_q[SB-1], sat_q});
  assign hmag  = (hsum < 0) ? (SB+1)'(-hsum) : (SB+1)'(hsum);
  assign bprod = (SB+asd_pkg::InteBits+1)'(hmag) * (SB+asd_pkg::InteBits+1)'(inte);
  assign braw  = bprod[SB+asd_pkg::InteBits:asd_pkg::InteBits];
  assign wgt   = (BB+1)'(asd_pkg::BlendOne) - {1'b0, blend_q};

  assign acc   = ($signed(AW'(p1_q)) <<< asd_pkg::AngShift)
               + ($signed(AW'(p2_q)) <<< asd_pkg::SinShift);
  assign res   = acc[AW-1:asd_pkg::OutShift];
  assign res_sat = (res > $signed(AW'({1'b0, {(SB-1){1'b1}}})))
                   ? {1'b0, {(SB-1){1'b1}}}
                 : (res < -$signed(AW'({1'b1, {(SB-1){1'b0}}})))
                   ? {1'b1, {(SB-1){1'b0}}}
                 : res[SB-1:0];

  always_ff @(posedge clk_i) begin
    case (state_q)
      asd_pkg::ST_QUOT: begin
        if (div_done) begin
          sat_q <= (xp_neg_q ^ neg_half_q) ? -$signed(quot) : $signed(quot);
        end
      end
      asd_pkg::ST_BLEND: begin
        blend_q <= (braw > (SB+1)'(asd_pkg::BlendOne)) ? asd_pkg::BlendOne
                                                      : braw[BB-1:0];
      end
      asd_pkg::ST_MIX: begin
        p1_q <= dry_q * $signed(SB'(wgt));
        p2_q <= sat_q * $signed(SB'(blend_q));
      end
      default: ;
    endcase
  end

  // channel history: clear on an input beat that flags clear_history, record sat once blended
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q[0] <= '0;
      prev_q[1] <= '0;
    end else if (in_beat && s_axis_tuser_i[1]) begin
      prev_q[s_axis_tuser_i[0]] <= '0;
    end else if (state_q == asd_pkg::ST_BLEND) begin
      prev_q[ch_q] <= sat_q;
    end
  end

  // output register: hold until taken, load the result when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == asd_pkg::ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == asd_pkg::ST_EMIT) && out_free) begin
      out_data_q <= res_sat;
    end
  end

endmodule

// ===== sim/adaptive_sine_saturation_drive_tb.sv =====
// ----------------------------------------------------------------------------
// adaptive_sine_saturation_drive_tb: self-checking bench for the sine drive
// Drives config writes and random sample beats with random gaps on both
// stream sides, predicts each output sample in fixed point and compares.
// ----------------------------------------------------------------------------
module adaptive_sine_saturation_drive_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TwoPiQ  = 64'sd1686629711;
  localparam longint PiQ     = 64'sd843314869;
  localparam longint InvTwoPi = 64'sd42722829;
  localparam longint DenBase = 64'sd13246752883;
  localparam longint OneQ22  = 64'sd1 <<< 22;
  localparam int     Latency = 80;
  localparam longint CycleLimit = 64'd2_000_000;

  // --------------------------------------------------------------------------
  // Drive model and expected-sample store
  // --------------------------------------------------------------------------
  class drive_scoreboard;
    logic [15:0] knob;
    logic        enable;
    longint      last_sine [2];
    logic [23:0] expected_q[$];
    int          errors;

    function new();
      knob = '0; enable = 1'b0;
      last_sine[0] = 0; last_sine[1] = 0;
      errors = 0;
    endfunction

    function void write_reg(asd_pkg::cfg_reg_e idx, logic [15:0] data);
      if (idx == asd_pkg::REG_DRIVE_KNOB) knob = data;
      else if (idx == asd_pkg::REG_EFFECT_ENABLE) enable = data[0];
    endfunction

    // Bhaskara sine of a Q28 angle, result in Q2.22
    function longint bhaskara_q22(longint ang);
      longint turns, pmx, xp, den, r;
      bit     upper;
      turns = (ang * InvTwoPi) / (64'sd1 <<< 56);
      ang   = ang - turns * TwoPiQ;
      upper = 1'b0;
      if (ang < 0) ang += TwoPiQ;
      if (ang > PiQ) begin
        ang -= PiQ;
        upper = 1'b1;
      end
      pmx = PiQ - ang;
      xp  = (ang * pmx) / (64'sd1 <<< 28);
      den = DenBase - 4 * xp;
      if (den <= 0) den = 1;
      r = (16 * xp * OneQ22) / den;
      return upper ? -r : r;
    endfunction

    function void note_sample(logic [23:0] smp, logic ch, logic clr);
      longint dry, ang, sat, sum, mag, inten, blend, acc, res, dv;
      dry = longint'($signed(smp));
      if (clr) last_sine[ch] = 0;
      ang = dry * 256;
      sat = bhaskara_q22(ang);
      inten = enable ? longint'(knob) * 8 : 0;
      if (inten > 65536) inten = 65536;
      sum = last_sine[ch] + sat;
      mag = sum < 0 ? -sum : sum;
      blend = (mag * inten) >>> 17;
      if (blend > OneQ22) blend = OneQ22;
      acc = ang * (OneQ22 - blend) + sat * 64 * blend;
      dv = 64'sd1 <<< 30;
      res = acc / dv;
      if ((acc % dv) != 0 && acc < 0) res -= 1;
      if (res > 8388607) res = 8388607;
      if (res < -8388608) res = -8388608;
      last_sine[ch] = sat;
      expected_q.push_back(24'(res));
    endfunction

    function void check_sample(logic [23:0] got);
      logic [23:0] exp_s;
      if (expected_q.size() == 0) begin
        $error("out_sample: no sample expected, actual %0d", $signed(got));
        errors++;
        return;
      end
      exp_s = expected_q.pop_front();
      if (got !== exp_s) begin
        $error("out_sample: expected %0d actual %0d", $signed(exp_s), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;   // [23:0] sample
  logic [1:0]  s_axis_tuser_i = '0;   // [0] channel, [1] clear_history
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;        // [23:0] out_sample

  drive_scoreboard sb = new();
  longint cycle_count = 0;
  bit     rx_stall_on = 1'b1;

  adaptive_sine_saturation_drive uut (.*);

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Output side: check each beat, throttle tready at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_sample(m_axis_tdata_o);
      m_axis_tready_i <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Step off the edge of the previous beat before driving a new one
  task automatic write_cfg(asd_pkg::cfg_reg_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the beat until accepted; record it on the accepting edge
  task automatic send_sample(logic [23:0] smp, logic ch, logic clr, bit gaps);
    @(posedge clk_i);
    if (gaps) idle_cycles(gap_len());
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    s_axis_tuser_i  <= {clr, ch};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(smp, ch, clr);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    idle_cycles(Latency);
  endtask

  task automatic random_burst(int n, bit gaps);
    logic [23:0] smp;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: smp = 24'($urandom_range(0, 15) - 8) <<< 20;          // near whole units
        1: smp = 24'($signed($urandom_range(0, 8000)) - 4000);   // near zero
        default: smp = 24'($urandom);
      endcase
      send_sample(smp, 1'($urandom), ($urandom_range(0, 7) == 0), gaps);
    end
  endtask

  initial begin
    logic [15:0] knobs [6];
    knobs = '{16'h0000, 16'hFFFF, 16'h2000, 16'h1FFF, 16'h0800, 16'h0001};
    idle_cycles(7);
    rst_ni <= 1'b1;
    idle_cycles(2);

    // Directed: extremes, half-turn edges, both channels, clears, spare regs
    write_cfg(asd_pkg::REG_SPARE2, 16'hFFFF);
    write_cfg(asd_pkg::REG_SPARE3, 16'hFFFF);
    send_sample(24'h000000, 1'b0, 1'b0, 1'b0);
    drain();
    write_cfg(asd_pkg::REG_DRIVE_KNOB, 16'hFFFF);
    send_sample(24'h7FFFFF, 1'b0, 1'b0, 1'b0);
    drain();
    write_cfg(asd_pkg::REG_EFFECT_ENABLE, 16'hFFFF);
    send_sample(24'h800000, 1'b0, 1'b0, 1'b0);
    send_sample(24'h7FFFFF, 1'b1, 1'b0, 1'b0);
    send_sample(24'h800000, 1'b1, 1'b1, 1'b0);
    send_sample(24'h324400, 1'b0, 1'b0, 1'b0);   // about pi
    send_sample(24'h3243F6, 1'b0, 1'b0, 1'b0);
    send_sample(24'hCDBC0A, 1'b1, 1'b0, 1'b0);   // about -pi
    send_sample(24'h6487ED, 1'b0, 1'b0, 1'b0);   // about 2*pi
    send_sample(24'h9B7813, 1'b1, 1'b0, 1'b0);
    send_sample(24'h555555, 1'b0, 1'b1, 1'b0);
    send_sample(24'hAAAAAA, 1'b1, 1'b1, 1'b0);
    send_sample(24'h000001, 1'b0, 1'b0, 1'b0);
    send_sample(24'hFFFFFF, 1'b1, 1'b0, 1'b0);
    drain();

    // Random phases over knob and enable settings
    for (int p = 0; p < 12; p++) begin
      write_cfg(asd_pkg::REG_DRIVE_KNOB, (p < 6) ? knobs[p] : 16'($urandom));
      write_cfg(asd_pkg::REG_EFFECT_ENABLE, 16'(p % 4 != 3));
      rx_stall_on = (p % 3 != 2);
      random_burst(135, (p % 3 != 1));
      drain();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/asd_pkg.sv
rtl/asd_mul.sv
rtl/asd_div.sv
rtl/adaptive_sine_saturation_drive.sv
sim/adaptive_sine_saturation_drive_tb.sv
